[rtl/smd_pkg.sv]
// Shared types and constants for the segmented message deframer.
// Used by smd_front, smd_back and segmented_message_deframer_top; no dependencies.
`timescale 1ns / 1ps

package smd_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int MESSAGE_MAX  = 65536;
    localparam int CAP_W        = 17;
    localparam int CAP_MIN      = 16;
    localparam int SEG_W        = $clog2(MAX_SEGMENTS + 1);
    localparam int HDR_BYTES    = 4;
    localparam int WORD_BYTES   = 8;
    localparam int WORD_SHIFT   = $clog2(WORD_BYTES);
    localparam int FQ_DEPTH     = 4;
    localparam int FQ_PTR_W     = $clog2(FQ_DEPTH);
    localparam int RQ_DEPTH     = 2;
    localparam int RQ_PTR_W     = $clog2(RQ_DEPTH);

    typedef enum logic [1:0] {
        CMD_DATA  = 2'd0,
        CMD_EOS   = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_LIMIT  = 2'd1,
        ST_FORMAT = 2'd2,
        ST_TRUNC  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_TABLE  = 3'b010,
        PH_BODY   = 3'b100
    } phase_t;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_in;
    } item_t;

    typedef struct packed {
        logic       consumed;
        logic [7:0] data_out;
        logic       in_frame;
        logic       first_of_frame;
        logic       last_of_frame;
        status_t    status;
    } result_t;

    // Decoded request as it travels from the front end to the framer engine.
    typedef struct packed {
        cmd_t       kind;
        logic [7:0] data;
    } op_t;

endpackage

[rtl/smd_front.sv]
// Front end of the deframer: decodes incoming requests and buffers them in a short queue.
// Depends on smd_pkg.
`timescale 1ns / 1ps

module smd_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  smd_pkg::item_t item,
    output logic           op_valid,
    input  logic           op_ready,
    output smd_pkg::op_t   op
);
    import smd_pkg::*;

    op_t                 q_mem [FQ_DEPTH];
    logic [FQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FQ_PTR_W:0]   count_reg, count_next;
    op_t                 new_op;
    logic                do_push;
    logic                do_pop;

    // Data bytes keep their payload; every other command carries a zero byte.
    always_comb
    begin
        new_op.data = '0;
        unique case (item.command)
            CMD_DATA:
            begin
                new_op.kind = CMD_DATA;
                new_op.data = item.data_in;
            end
            CMD_EOS:   new_op.kind = CMD_EOS;
            CMD_CLEAR: new_op.kind = CMD_CLEAR;
            CMD_NONE:  new_op.kind = CMD_NONE;
        endcase
    end

    assign full     = (count_reg == (FQ_PTR_W + 1)'(FQ_DEPTH));
    assign op_valid = (count_reg != '0);
    assign op       = q_mem[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = op_valid && op_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_ptr_reg] <= new_op;
        end
    end

endmodule

[rtl/smd_back.sv]
// Framer engine: walks header, segment table and body one byte per cycle while the result
// queue has room, then queues results there. Holds the capacity register. Depends on smd_pkg.
`timescale 1ns / 1ps

module smd_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    op_valid,
    output logic                    op_ready,
    input  smd_pkg::op_t            op,
    input  logic                    cfg_write,
    input  logic [smd_pkg::CAP_W-1:0] cfg_data,
    output logic                    empty,
    input  logic                    pop,
    output smd_pkg::result_t        result
);
    import smd_pkg::*;

    // Framer state.
    phase_t             phase_reg, phase_next;
    logic [CAP_W-1:0]   byte_count_reg, byte_count_next;
    logic [CAP_W-1:0]   target_reg, target_next;
    logic [SEG_W-1:0]   seg_count_reg, seg_count_next;
    logic [SEG_W-1:0]   tbl_idx_reg, tbl_idx_next;
    logic [CAP_W-1:0]   total_reg, total_next;
    status_t            pending_reg, pending_next;
    status_t            sticky_reg, sticky_next;
    logic [CAP_W-1:0]   capacity_reg, capacity_next;
    logic [23:0]        word_reg, word_next;

    // Result queue.
    result_t            rq_mem [RQ_DEPTH];
    logic [RQ_PTR_W-1:0] rq_wr_reg, rq_wr_next;
    logic [RQ_PTR_W-1:0] rq_rd_reg, rq_rd_next;
    logic [RQ_PTR_W:0]  rq_count_reg, rq_count_next;

    logic               take;
    logic               rq_pop;
    result_t            res;
    status_t            err;

    logic [1:0]         pos;
    logic [31:0]        word_full;
    logic [CAP_W-1:0]   bc_inc;
    logic [SEG_W-1:0]   hdr_seg;
    logic               hdr_too_many;
    logic [CAP_W-1:0]   hdr_tbl;
    logic               hdr_over;
    logic [CAP_W-1:0]   headroom;
    logic               tot_over;
    logic               w_over;
    logic [CAP_W-1:0]   total_add;
    logic               tbl_end_over;

    assign op_ready = (rq_count_reg != (RQ_PTR_W + 1)'(RQ_DEPTH));
    assign take     = op_valid && op_ready;
    assign empty    = (rq_count_reg == '0);
    assign rq_pop   = pop && !empty;
    assign result   = rq_mem[rq_rd_reg];

    // Word and limit arithmetic, all relative to the byte being taken.
    assign pos          = byte_count_reg[1:0];
    assign word_full    = {op.data, word_reg};
    assign bc_inc       = byte_count_reg + CAP_W'(1);
    assign hdr_seg      = SEG_W'(word_full) + SEG_W'(1);
    assign hdr_too_many = (word_full >= 32'(MAX_SEGMENTS));
    assign hdr_tbl      = ((CAP_W'(hdr_seg) + CAP_W'(2)) >> 1) << WORD_SHIFT;
    assign hdr_over     = (hdr_tbl > capacity_reg);
    assign headroom     = (capacity_reg - total_reg) >> WORD_SHIFT;
    assign tot_over     = (total_reg > capacity_reg);
    assign w_over       = (word_full > 32'(headroom));
    assign total_add    = total_reg
                        + (CAP_W'(word_full[CAP_W-WORD_SHIFT-1:0]) << WORD_SHIFT);
    assign tbl_end_over = (target_reg > capacity_reg);

    always_comb
    begin
        priority if (cfg_data < CAP_W'(CAP_MIN))
        begin
            capacity_next = CAP_W'(CAP_MIN);
        end
        else if (cfg_data > CAP_W'(MESSAGE_MAX))
        begin
            capacity_next = CAP_W'(MESSAGE_MAX);
        end
        else
        begin
            capacity_next = cfg_data;
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        byte_count_next = byte_count_reg;
        target_next     = target_reg;
        seg_count_next  = seg_count_reg;
        tbl_idx_next    = tbl_idx_reg;
        total_next      = total_reg;
        pending_next    = pending_reg;
        sticky_next     = sticky_reg;
        word_next       = word_reg;
        res             = '0;
        err             = ST_OK;

        if (take)
        begin
            unique case (op.kind)
                CMD_CLEAR:
                begin
                    phase_next      = PH_HEADER;
                    byte_count_next = '0;
                    target_next     = CAP_W'(HDR_BYTES);
                    seg_count_next  = '0;
                    tbl_idx_next    = '0;
                    total_next      = '0;
                    pending_next    = ST_OK;
                    sticky_next     = ST_OK;
                end
                CMD_EOS:
                begin
                    if (sticky_reg != ST_OK)
                    begin
                        res.status = sticky_reg;
                    end
                    else if (byte_count_reg != '0)
                    begin
                        res.status = ST_TRUNC;
                    end
                end
                CMD_NONE:
                begin
                end
                CMD_DATA:
                begin
                    if (sticky_reg != ST_OK)
                    begin
                        res.status = sticky_reg;
                    end
                    else
                    begin
                        res.consumed       = 1'b1;
                        res.data_out       = op.data;
                        res.in_frame       = 1'b1;
                        res.first_of_frame = (byte_count_reg == '0);
                        byte_count_next    = bc_inc;

                        // Bytes of a word are gathered low lane first; the top byte
                        // completes the word directly from the input.
                        unique case (pos)
                            2'd0: word_next[7:0]   = op.data;
                            2'd1: word_next[15:8]  = op.data;
                            2'd2: word_next[23:16] = op.data;
                            2'd3: word_next        = word_reg;
                        endcase

                        unique case (phase_reg)
                            PH_HEADER:
                            begin
                                if (pos == 2'd3)
                                begin
                                    if (hdr_too_many)
                                    begin
                                        err = ST_LIMIT;
                                    end
                                    else
                                    begin
                                        seg_count_next = hdr_seg;
                                        target_next    = hdr_tbl;
                                        if (hdr_over)
                                        begin
                                            err = ST_LIMIT;
                                        end
                                        else
                                        begin
                                            phase_next   = PH_TABLE;
                                            tbl_idx_next = '0;
                                            total_next   = hdr_tbl;
                                            pending_next = ST_OK;
                                        end
                                    end
                                end
                            end
                            PH_TABLE:
                            begin
                                // Padding words beyond the segment count are skipped.
                                if (pos == 2'd3 && tbl_idx_reg < seg_count_reg)
                                begin
                                    tbl_idx_next = tbl_idx_reg + 1'b1;
                                    if (pending_reg == ST_OK)
                                    begin
                                        priority if (tbl_idx_reg == '0 && word_full == '0)
                                        begin
                                            pending_next = ST_FORMAT;
                                        end
                                        else if (tot_over || w_over)
                                        begin
                                            pending_next = ST_LIMIT;
                                        end
                                        else
                                        begin
                                            total_next = total_add;
                                        end
                                    end
                                end
                                // Errors found in the table surface on its last byte.
                                if (bc_inc == target_reg)
                                begin
                                    priority if (tbl_end_over)
                                    begin
                                        err = ST_LIMIT;
                                    end
                                    else if (pending_next != ST_OK)
                                    begin
                                        err = pending_next;
                                    end
                                    else
                                    begin
                                        target_next = total_next;
                                        phase_next  = PH_BODY;
                                    end
                                end
                            end
                            PH_BODY:
                            begin
                                if (bc_inc >= target_reg)
                                begin
                                    res.last_of_frame = 1'b1;
                                    phase_next        = PH_HEADER;
                                    byte_count_next   = '0;
                                    target_next       = CAP_W'(HDR_BYTES);
                                    seg_count_next    = '0;
                                    tbl_idx_next      = '0;
                                    total_next        = '0;
                                    pending_next      = ST_OK;
                                end
                            end
                            default:
                            begin
                            end
                        endcase

                        if (err != ST_OK)
                        begin
                            sticky_next = err;
                            res.status  = err;
                        end
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        rq_wr_next    = rq_wr_reg;
        rq_rd_next    = rq_rd_reg;
        rq_count_next = rq_count_reg;
        if (take)
        begin
            rq_wr_next = (rq_wr_reg == RQ_PTR_W'(RQ_DEPTH - 1)) ? '0 : rq_wr_reg + 1'b1;
        end
        if (rq_pop)
        begin
            rq_rd_next = (rq_rd_reg == RQ_PTR_W'(RQ_DEPTH - 1)) ? '0 : rq_rd_reg + 1'b1;
        end
        if (take && !rq_pop)
        begin
            rq_count_next = rq_count_reg + 1'b1;
        end
        else if (rq_pop && !take)
        begin
            rq_count_next = rq_count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            byte_count_reg <= '0;
            target_reg     <= CAP_W'(HDR_BYTES);
            seg_count_reg  <= '0;
            tbl_idx_reg    <= '0;
            total_reg      <= '0;
            pending_reg    <= ST_OK;
            sticky_reg     <= ST_OK;
            capacity_reg   <= CAP_W'(MESSAGE_MAX);
            rq_wr_reg      <= '0;
            rq_rd_reg      <= '0;
            rq_count_reg   <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
            target_reg     <= target_next;
            seg_count_reg  <= seg_count_next;
            tbl_idx_reg    <= tbl_idx_next;
            total_reg      <= total_next;
            pending_reg    <= pending_next;
            sticky_reg     <= sticky_next;
            rq_wr_reg      <= rq_wr_next;
            rq_rd_reg      <= rq_rd_next;
            rq_count_reg   <= rq_count_next;
            if (cfg_write)
            begin
                capacity_reg <= capacity_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        if (take)
        begin
            rq_mem[rq_wr_reg] <= res;
        end
    end

    // A completed frame leaves the framer ready for the next header.
    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        take && res.last_of_frame |=> phase_reg == PH_HEADER && byte_count_reg == '0)
        else $error("framer did not restart after a completed frame");

    // While halted, data bytes are refused and the sticky error is reported.
    a_halted_refuses: assert property (@(posedge clk) disable iff (!rst_n)
        take && op.kind == CMD_DATA && sticky_reg != ST_OK
        |-> !res.consumed && res.status == sticky_reg)
        else $error("data byte taken while an error is sticky");

    // Only a clear request releases a sticky error.
    a_sticky_holds: assert property (@(posedge clk) disable iff (!rst_n)
        sticky_reg != ST_OK && !(take && op.kind == CMD_CLEAR)
        |=> sticky_reg == $past(sticky_reg))
        else $error("sticky error changed without a clear");

    // Every processed request shows up as a waiting result.
    a_result_queued: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> !empty)
        else $error("processed request produced no waiting result");

endmodule

[rtl/segmented_message_deframer_top.sv]
// A request accepted into the front queue waits there until it reaches the head and the
// result queue has room; the framer engine then takes it, works it out and writes its result
// into the result queue, whose head drives the result ports. Throughput: one request per cycle
// while the result queue has room, set by the per-byte framer update in smd_back.
// Either side may stall; a four-entry request queue and a two-entry result queue decouple them.
// Reset (rst_n, asynchronous, active low) empties both queues, clears the framer and
// the sticky error, and sets capacity to its largest value.
// Top level of the segmented message deframer; instantiates smd_front and smd_back.
// Depends on smd_pkg.
`timescale 1ns / 1ps

module segmented_message_deframer_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  smd_pkg::item_t            item,
    output logic                      empty,
    input  logic                      pop,
    output smd_pkg::result_t          result,
    input  logic                      cfg_write,
    input  logic [smd_pkg::CAP_W-1:0] cfg_data
);
    import smd_pkg::*;

    // Decoded requests flow from the front end to the engine through this handshake.
    // The engine takes one request per cycle while its result queue has room.
    logic op_valid;
    logic op_ready;
    op_t  op;

    // The front end accepts a request whenever its queue is not full, so the
    // producer keeps streaming even while a finished result waits to be popped.
    smd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .op_valid (op_valid),
        .op_ready (op_ready),
        .op       (op)
    );

    // The engine tracks header, segment table and body, checks the limits against
    // the capacity register, and reports errors that stay until a clear request.
    // Capacity writes are saturated into the legal range inside the engine.
    smd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_ready  (op_ready),
        .op        (op),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

[dv/tb_segmented_message_deframer_top.sv]
// Self-checking testbench for segmented_message_deframer_top: a directed table, then
// random framed traffic checked against a behavioral deframer kept in this file.
// Depends on smd_pkg and the RTL of the deframer.
`timescale 1ns / 1ps

module tb_segmented_message_deframer_top;

    import smd_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_CYCLES     = 60;
    localparam int DRAIN_CYCLES    = 20;
    localparam int ITEMS_PER_PHASE = 340;
    localparam int NUM_PHASES      = 6;

    // One row of the directed table. A row either writes capacity or sends one
    // request; typed rows carry their expected result, the others use the model.
    typedef struct {
        bit          is_cfg;
        logic [16:0] cap;
        item_t       req;
        bit          typed;
        result_t     want;
    } dir_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    item_t              item = '0;
    logic               empty;
    logic               pop = 1'b0;
    result_t            result;
    logic               cfg_write = 1'b0;
    logic [CAP_W-1:0]   cfg_data = '0;

    // Behavioral copy of the deframer state and its capacity register.
    logic [CAP_W-1:0]   capacity_q;
    phase_t             fr_phase;
    logic [CAP_W-1:0]   fr_count;
    logic [CAP_W-1:0]   fr_target;
    logic [CAP_W-1:0]   fr_total;
    logic [6:0]         fr_segs;
    logic [6:0]         fr_tidx;
    logic [31:0]        fr_word;
    status_t            fr_pend;
    status_t            fr_sticky;

    result_t            expected_results[$];
    result_t            oldest;
    dir_row_t           dir_rows[$];

    int                 fail_cnt = 0;
    int                 cycle_cnt = 0;
    int                 items_taken = 0;
    int                 stall_left = 0;
    bit                 rx_hold = 1'b0;
    bit                 rx_bursty = 1'b0;
    bit                 tx_bursty = 1'b0;

    segmented_message_deframer_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("tb_segmented_message_deframer_top: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Behavioral deframer
    // ------------------------------------------------------------------

    function automatic void restart_framer();
        fr_phase  = PH_HEADER;
        fr_count  = '0;
        fr_target = CAP_W'(HDR_BYTES);
        fr_segs   = '0;
        fr_word   = '0;
        fr_tidx   = '0;
        fr_total  = '0;
        fr_pend   = ST_OK;
        fr_sticky = ST_OK;
    endfunction

    // Capacity saturates at both ends of its legal range.
    function automatic void set_capacity(logic [CAP_W-1:0] value);
        if (value < CAP_W'(CAP_MIN))
            capacity_q = CAP_W'(CAP_MIN);
        else if (value > CAP_W'(MESSAGE_MAX))
            capacity_q = CAP_W'(MESSAGE_MAX);
        else
            capacity_q = value;
    endfunction

    // Works out the result of one request and advances the framer state.
    function automatic result_t deframe_request(item_t req);
        result_t     r;
        status_t     err;
        int unsigned pos;
        int unsigned w;
        int unsigned tbl;

        r   = '0;
        err = ST_OK;
        case (cmd_t'(req.command))
            CMD_CLEAR:
            begin
                restart_framer();
                return r;
            end
            CMD_EOS:
            begin
                // A sticky error wins over truncation; a clean boundary reports ok.
                if (fr_sticky != ST_OK)
                    r.status = fr_sticky;
                else
                    r.status = (fr_count != 0) ? ST_TRUNC : ST_OK;
                return r;
            end
            CMD_NONE:
                return r;
            default:
                ;
        endcase

        // A halted framer refuses data and repeats its error.
        if (fr_sticky != ST_OK)
        begin
            r.status = fr_sticky;
            return r;
        end

        r.consumed       = 1'b1;
        r.data_out       = req.data_in;
        r.in_frame       = 1'b1;
        r.first_of_frame = (fr_count == 0);

        pos      = fr_count;
        fr_word  = fr_word | (32'(req.data_in) << (8 * (pos % 4)));
        fr_count = fr_count + 1'b1;

        case (fr_phase)
            PH_HEADER:
            begin
                if (pos % 4 == 3)
                begin
                    w       = fr_word;
                    fr_word = '0;
                    if (w >= MAX_SEGMENTS)
                        err = ST_LIMIT;
                    else
                    begin
                        fr_segs   = 7'(w + 1);
                        tbl       = (w + 3) / 2 * WORD_BYTES;
                        fr_target = CAP_W'(tbl);
                        if (tbl > capacity_q)
                            err = ST_LIMIT;
                        else
                        begin
                            fr_phase = PH_TABLE;
                            fr_tidx  = '0;
                            fr_total = CAP_W'(tbl);
                            fr_pend  = ST_OK;
                        end
                    end
                end
            end
            PH_TABLE:
            begin
                // Each segment word is judged as it completes; padding is skipped.
                if (pos % 4 == 3)
                begin
                    w       = fr_word;
                    fr_word = '0;
                    if (fr_tidx < fr_segs)
                    begin
                        if (fr_pend == ST_OK)
                        begin
                            if (fr_tidx == 0 && w == 0)
                                fr_pend = ST_FORMAT;
                            else if (fr_total > capacity_q ||
                                     w > (capacity_q - fr_total) / WORD_BYTES)
                                fr_pend = ST_LIMIT;
                            else
                                fr_total = CAP_W'(fr_total + w * WORD_BYTES);
                        end
                        fr_tidx = fr_tidx + 1'b1;
                    end
                end
                // Table errors surface only on the last table byte.
                if (fr_count == fr_target)
                begin
                    if (fr_target > capacity_q)
                        err = ST_LIMIT;
                    else if (fr_pend != ST_OK)
                        err = fr_pend;
                    else
                    begin
                        fr_target = fr_total;
                        fr_phase  = PH_BODY;
                    end
                end
            end
            default:
            begin
                fr_word = '0;
                if (fr_count >= fr_target)
                begin
                    r.last_of_frame = 1'b1;
                    restart_framer();
                end
            end
        endcase

        if (err != ST_OK)
        begin
            fr_sticky = err;
            r.status  = err;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Helpers for building requests and table rows
    // ------------------------------------------------------------------

    function automatic item_t mk_item(cmd_t c, logic [7:0] d);
        item_t it;
        it.command = c;
        it.data_in = d;
        return it;
    endfunction

    function automatic result_t mk_result(logic c, logic [7:0] d, logic inf, logic first,
                                          logic last, status_t st);
        result_t r;
        r.consumed       = c;
        r.data_out       = d;
        r.in_frame       = inf;
        r.first_of_frame = first;
        r.last_of_frame  = last;
        r.status         = st;
        return r;
    endfunction

    function automatic dir_row_t req_row(cmd_t c, logic [7:0] d, bit typed, result_t want);
        dir_row_t row;
        row.is_cfg = 1'b0;
        row.cap    = '0;
        row.req    = mk_item(c, d);
        row.typed  = typed;
        row.want   = want;
        return row;
    endfunction

    function automatic dir_row_t cfg_row(logic [CAP_W-1:0] value);
        dir_row_t row;
        row.is_cfg = 1'b1;
        row.cap    = value;
        row.req    = '0;
        row.typed  = 1'b0;
        row.want   = '0;
        return row;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offers one request after a random gap and holds it until the block takes it.
    // The expectation is recorded at the accepting edge.
    task automatic send(input item_t req, input bit typed, input result_t want);
        int      gap;
        result_t r;

        gap = tx_bursty ? 0 : $urandom_range(0, 3);
        repeat (gap)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
        @(negedge clk);
        push <= 1'b1;
        item <= req;
        @(posedge clk);
        while (full)
            @(posedge clk);
        r = deframe_request(req);
        expected_results.push_back(typed ? want : r);
        if (r.consumed || cmd_t'(req.command) == CMD_EOS || cmd_t'(req.command) == CMD_CLEAR)
            items_taken++;
    endtask

    // Stops offering requests and waits until every expected result has come back.
    task automatic wait_idle();
        @(negedge clk);
        push <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        set_capacity(value);
    endtask

    // One random stretch of traffic: mostly well-formed frames with random contents,
    // some broken on purpose (truncated, bad segment count, empty first segment,
    // oversized segment) and some plain noise, followed by recovery if needed.
    task automatic run_frame();
        int          kind;
        int          segs;
        int          cut;
        int          bad_idx;
        int          tbl;
        int unsigned body_words;
        logic [31:0] hdr;
        logic [31:0] w;
        logic [7:0]  fb[$];

        tx_bursty = ($urandom_range(0, 5) == 0);
        rx_bursty = ($urandom_range(0, 5) == 0);
        kind      = $urandom_range(0, 99);

        if (kind >= 91 && kind < 96)
        begin
            // Noise: any command, any byte.
            repeat ($urandom_range(1, 12))
                send(mk_item(cmd_t'($urandom_range(0, 3)), 8'($urandom())), 1'b0, '0);
            send(mk_item(CMD_CLEAR, 8'($urandom())), 1'b0, '0);
            return;
        end

        segs       = ($urandom_range(0, 9) == 0) ? $urandom_range(5, MAX_SEGMENTS)
                                                 : $urandom_range(1, 4);
        bad_idx    = $urandom_range(0, segs - 1);
        hdr        = 32'(segs - 1);
        body_words = 0;
        if (kind >= 85 && kind < 91)
            hdr = $urandom() | 32'h40;
        for (int i = 0; i < 4; i++)
            fb.push_back(8'(hdr >> (8 * i)));

        tbl = (segs + 2) / 2 * WORD_BYTES;
        for (int i = 0; i < (tbl - HDR_BYTES) / 4; i++)
        begin
            if (i >= segs)
                w = $urandom();
            else
            begin
                w = (segs > 4) ? $urandom_range(0, 1) : $urandom_range(0, 3);
                if (i == 0 && w == 0)
                    w = 1;
                if (i == 0 && kind >= 78 && kind < 85)
                    w = 0;
                // Any word of 8192 or more overflows even the largest capacity.
                if (kind >= 96 && i == bad_idx)
                    w = $urandom() | 32'h2000;
                else
                    body_words += w;
            end
            for (int k = 0; k < 4; k++)
                fb.push_back(8'(w >> (8 * k)));
        end
        if (kind < 96)
            repeat (body_words * WORD_BYTES)
                fb.push_back(8'($urandom()));

        cut = fb.size();
        if (kind >= 70 && kind < 78)
            cut = $urandom_range(1, fb.size() - 1);
        if (kind >= 85 && kind < 91)
            cut = HDR_BYTES + $urandom_range(0, 3);
        for (int i = 0; i < cut; i++)
            send(mk_item(CMD_DATA, fb[i]), 1'b0, '0);

        if (fr_sticky != ST_OK || fr_count != 0)
        begin
            // Bytes sent into a halted framer must be refused.
            if (fr_sticky != ST_OK)
                repeat ($urandom_range(0, 2))
                    send(mk_item(CMD_DATA, 8'($urandom())), 1'b0, '0);
            send(mk_item(CMD_EOS, 8'($urandom())), 1'b0, '0);
            send(mk_item(CMD_CLEAR, 8'($urandom())), 1'b0, '0);
        end
        else if ($urandom_range(0, 4) == 0)
            send(mk_item(CMD_EOS, 8'($urandom())), 1'b0, '0);
        if ($urandom_range(0, 19) == 0)
            send(mk_item(CMD_CLEAR, 8'($urandom())), 1'b0, '0);
    endtask

    // ------------------------------------------------------------------
    // Receiver side
    // ------------------------------------------------------------------

    // Drives pop once per falling edge. A hold request turns into a long stall
    // counted here, which backs the block up until it refuses new requests.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rx_hold)
            begin
                rx_hold    = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else
                pop <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_cnt++;
        end
    endtask

    // Every result taken from the block is compared with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result popped while no request was outstanding");
                fail_cnt++;
            end
            else
            begin
                oldest = expected_results.pop_front();
                check_field("consumed", 8'(oldest.consumed), 8'(result.consumed));
                check_field("data_out", oldest.data_out, result.data_out);
                check_field("in_frame", 8'(oldest.in_frame), 8'(result.in_frame));
                check_field("first_of_frame", 8'(oldest.first_of_frame),
                            8'(result.first_of_frame));
                check_field("last_of_frame", 8'(oldest.last_of_frame),
                            8'(result.last_of_frame));
                check_field("status", 8'(oldest.status), 8'(result.status));
            end
            stall_left = rx_bursty ? 0 : $urandom_range(0, 3);
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        logic [CAP_W-1:0] cap_value;
        int               phase_end;

        capacity_q = CAP_W'(MESSAGE_MAX);
        restart_framer();

        // Directed table. Typed rows check values that are plain from the spec:
        // the first byte, error bytes, refused bytes, end-of-stream and clear.
        dir_rows.push_back(req_row(CMD_EOS, 8'h00, 1'b1, mk_result(0, 0, 0, 0, 0, ST_OK)));
        dir_rows.push_back(req_row(CMD_NONE, 8'hFF, 1'b1, mk_result(0, 0, 0, 0, 0, ST_OK)));
        dir_rows.push_back(req_row(CMD_DATA, 8'h00, 1'b1, mk_result(1, 0, 1, 1, 0, ST_OK)));
        // Part of a header has arrived, so end of stream reports truncation.
        dir_rows.push_back(req_row(CMD_EOS, 8'hFF, 1'b1, mk_result(0, 0, 0, 0, 0, ST_TRUNC)));
        // Rest of a one-segment header, then a table word of zero: empty first segment.
        repeat (6)
            dir_rows.push_back(req_row(CMD_DATA, 8'h00, 1'b0, '0));
        dir_rows.push_back(req_row(CMD_DATA, 8'h00, 1'b1,
                                   mk_result(1, 0, 1, 0, 0, ST_FORMAT)));
        dir_rows.push_back(req_row(CMD_DATA, 8'hFF, 1'b1,
                                   mk_result(0, 0, 0, 0, 0, ST_FORMAT)));
        dir_rows.push_back(req_row(CMD_EOS, 8'h00, 1'b1, mk_result(0, 0, 0, 0, 0, ST_FORMAT)));
        dir_rows.push_back(req_row(CMD_CLEAR, 8'hFF, 1'b1, mk_result(0, 0, 0, 0, 0, ST_OK)));
        // An all-ones segment count is far above the segment limit.
        repeat (3)
            dir_rows.push_back(req_row(CMD_DATA, 8'hFF, 1'b0, '0));
        dir_rows.push_back(req_row(CMD_DATA, 8'hFF, 1'b1,
                                   mk_result(1, 8'hFF, 1, 0, 0, ST_LIMIT)));
        dir_rows.push_back(req_row(CMD_CLEAR, 8'h00, 1'b1, mk_result(0, 0, 0, 0, 0, ST_OK)));
        // Capacity written as zero saturates to the minimum; four segments then need
        // a header plus table larger than the frame may be.
        dir_rows.push_back(cfg_row('0));
        dir_rows.push_back(req_row(CMD_DATA, 8'h03, 1'b0, '0));
        repeat (2)
            dir_rows.push_back(req_row(CMD_DATA, 8'h00, 1'b0, '0));
        dir_rows.push_back(req_row(CMD_DATA, 8'h00, 1'b1,
                                   mk_result(1, 0, 1, 0, 0, ST_LIMIT)));
        dir_rows.push_back(req_row(CMD_CLEAR, 8'hFF, 1'b1, mk_result(0, 0, 0, 0, 0, ST_OK)));
        // All ones saturates to the maximum.
        dir_rows.push_back(cfg_row('1));

        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
            begin
                wait_idle();
                write_capacity(dir_rows[i].cap);
            end
            else
                send(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
        end

        // Random phases, each under its own capacity. The sender drains the block
        // before every capacity write.
        items_taken = 0;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:       cap_value = CAP_W'(MESSAGE_MAX);
                1:       cap_value = CAP_W'($urandom_range(64, 600));
                2:       cap_value = CAP_W'(CAP_MIN);
                3:       cap_value = '1;
                4:       cap_value = CAP_W'($urandom_range(0, CAP_MIN - 1));
                default: cap_value = CAP_W'($urandom_range(1000, 4000));
            endcase
            wait_idle();
            write_capacity(cap_value);
            // In the second phase the receiver stops for a long while, so the
            // block fills up and holds off new requests.
            if (p == 1)
                rx_hold = 1'b1;
            phase_end = items_taken + ITEMS_PER_PHASE;
            while (items_taken < phase_end)
                run_frame();
        end

        wait_idle();
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (fail_cnt == 0)
            $display("tb_segmented_message_deframer_top: PASS");
        else
            $display("tb_segmented_message_deframer_top: FAIL");
        $finish;
    end

endmodule
